// ===== sv/sha256_hash_engine_unit_macros.svh =====
// assertion macros for the sha256 engine
`ifndef SHA256_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA256_HASH_ENGINE_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define SHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 check failed");
// next-cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 check failed");
`endif

// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// types, constants and round functions shared by the sha256 engine
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_DATA   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
	} sha_state_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[i];
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== sv/sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// byte-stream sha-256 engine with queued front end
// ----------------------------------------------------------------------------
// channel  signals                         direction
// in       valid/ready cmd data_byte        into block
// out      out_valid/out_ready digest_word  out of block
//          word_index last
// a byte word that fills a block starts a compression: one load, 64 rounds
// in one shared round unit, then one hash add
// finish pads and compresses one or two blocks, then emits eight output words
// a four-entry queue keeps taking words while the core compresses
// reset clears control and loads the initial hash words
module sha256_hash_engine_unit import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
`include "sha256_hash_engine_unit_macros.svh"
	logic      q_valid, q_ready;
	sha_item_t q_item;

	sha_front u_front (
		.clk, .arst_n, .valid, .ready, .cmd, .data_byte,
		.q_valid, .q_ready, .q_item
	);

	sha_core u_core (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.valid(out_valid), .ready(out_ready),
		.digest_word, .word_index, .last
	);

	`SHA_ASSERT_IMP(a_last_idx, out_valid && last, word_index == 3'd7)
	`SHA_ASSERT_NXT(a_idx_step, out_valid && out_ready && !last,
		out_valid && word_index == $past(word_index) + 3'd1)
	`SHA_ASSERT_IMP(a_no_take_emit, out_valid, !q_ready)
endmodule

// ===== sv/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// accepts command words and queues them for the compression core
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	output logic       q_valid,
	input  logic       q_ready,
	output sha_item_t  q_item
);
	sha_item_t  mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic push, pop;

	// unused command code dropped here
	assign ready   = (cnt_q != (QAW+1)'(QDEPTH));
	assign push    = valid && ready && (cmd != CMD_UNUSED);
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{cmd: cmd, data: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
endmodule

// ===== sv/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// byte packing, padding, 64-round compression and digest output
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  sha_item_t   q_item,
	output logic        valid,
	input  logic        ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	sha_state_t state_q, state_d;
	word_t      hash_q [8];
	word_t      buf_q [16];
	word_t      w_q [16];
	word_t      v_q [8];
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [5:0] rnd_q;
	logic       fin_q;
	logic       two_q;
	logic [2:0] idx_q;
	logic       take;

	word_t wi, t1, t2, s0, s1, x1, x14;
	logic [3:0] bi;
	logic [1:0] bo;

	assign bi = fill_q[5:2];
	assign bo = fill_q[1:0];

	always_comb begin
		x1  = w_q[1];
		x14 = w_q[14];
		s0  = rotr(x1, 7) ^ rotr(x1, 18) ^ (x1 >> 3);
		s1  = rotr(x14, 17) ^ rotr(x14, 19) ^ (x14 >> 10);
		wi  = w_q[0] + s0 + s1 + w_q[9];
		t1  = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_q[0];
		t2  = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.cmd == CMD_FINISH) state_d = ST_PAD;
				else if (q_valid && q_item.cmd == CMD_DATA && fill_q == 6'd63)
					state_d = ST_ROUND;
			end
			ST_PAD: state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (two_q) state_d = ST_PAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT: if (ready && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready     = (state_q == ST_IDLE);
		valid       = (state_q == ST_EMIT);
		digest_word = hash_q[idx_q];
		word_index  = idx_q;
		last        = (idx_q == 3'd7);
	end

	assign take     = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else begin
			state_q <= state_d;
			if (take && q_item.cmd == CMD_START) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
				fill_q <= '0;
				bits_q <= '0;
			end
			if (take && q_item.cmd == CMD_DATA) begin
				bits_q <= bits_q + 64'd8;
				fill_q <= fill_q + 6'd1;
			end
			if (take && q_item.cmd == CMD_FINISH) begin
				fin_q <= 1'b1;
				two_q <= (fill_q > 6'd55);
			end
			if (state_q == ST_PAD) begin
				fill_q <= '0;
			end
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
				two_q <= 1'b0;
			end
			if (state_q == ST_EMIT && ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) fin_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (take && q_item.cmd == CMD_DATA) begin
			case (bo)
				2'd0: buf_q[bi] <= {q_item.data, 24'd0};
				2'd1: buf_q[bi][23:16] <= q_item.data;
				2'd2: buf_q[bi][15:8] <= q_item.data;
				default: buf_q[bi][7:0] <= q_item.data;
			endcase
		end
		if (take && q_item.cmd == CMD_FINISH) begin
			// pad mark, zero tail of the current word and zero the later words
			for (int j = 0; j < 16; j++)
				if (4'(j) > bi) buf_q[j] <= '0;
			case (bo)
				2'd0: buf_q[bi] <= {PAD_MARK, 24'd0};
				2'd1: buf_q[bi][23:0] <= {PAD_MARK, 16'd0};
				2'd2: buf_q[bi][15:0] <= {PAD_MARK, 8'd0};
				default: buf_q[bi][7:0] <= PAD_MARK;
			endcase
		end
		if (take && q_item.cmd == CMD_DATA && fill_q == 6'd63) begin
			for (int j = 0; j < 15; j++) w_q[j] <= buf_q[j];
			w_q[15] <= {buf_q[15][31:8], q_item.data};
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end
		if (state_q == ST_PAD) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			for (int j = 0; j < 14; j++) w_q[j] <= buf_q[j];
			w_q[14] <= two_q ? buf_q[14] : bits_q[63:32];
			w_q[15] <= two_q ? buf_q[15] : bits_q[31:0];
			if (two_q) for (int j = 0; j < 16; j++) buf_q[j] <= '0;
		end
		if (state_q == ST_ROUND) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= wi;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule
